// ===== rtl/lfsc_pkg.sv =====
// Shared types and constants of the line-follow steering controller.
`default_nettype none

package lfsc_pkg;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_ERROR,
        ST_DECIDE,
        ST_MUL_P,
        ST_MUL_D,
        ST_FINISH
    } state_t;

    // Drive mode codes.
    typedef enum logic [1:0] {
        MODE_TRACK = 2'd0,
        MODE_LEFT  = 2'd1,
        MODE_RIGHT = 2'd2
    } drive_mode_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CENTER_DUTY = 3'd0;
    localparam logic [2:0] CFG_UPPER_LIMIT = 3'd1;
    localparam logic [2:0] CFG_LOWER_LIMIT = 3'd2;
    localparam logic [2:0] CFG_KP          = 3'd3;
    localparam logic [2:0] CFG_KD          = 3'd4;
    localparam logic [2:0] CFG_ERROR_WIN   = 3'd5;
    localparam logic [2:0] CFG_READY_HOLD  = 3'd6;
    localparam logic [2:0] CFG_LOOP_HOLD   = 3'd7;

    // Register reset values.
    localparam logic [9:0]  RST_CENTER_DUTY = 10'd390;
    localparam logic [9:0]  RST_UPPER_LIMIT = 10'd600;
    localparam logic [9:0]  RST_LOWER_LIMIT = 10'd180;
    localparam logic [9:0]  RST_KP          = 10'd320;
    localparam logic [9:0]  RST_KD          = 10'd250;
    localparam logic [14:0] RST_ERROR_WIN   = 15'd6554;
    localparam logic [7:0]  RST_READY_HOLD  = 8'd20;
    localparam logic [7:0]  RST_LOOP_HOLD   = 8'd40;

    // Detector thresholds on the vertical coils.
    localparam logic [11:0] VERT_ARM_LOW  = 12'd100;
    localparam logic [11:0] VERT_ARM_HIGH = 12'd600;
    localparam logic [11:0] VERT_ENTER    = 12'd1200;
    localparam logic [12:0] VERT_IMBAL    = 13'd600;

    // Roundabout steering.
    localparam logic [9:0] ROUND_GAIN  = 10'd150;
    localparam logic [9:0] LEFT_BASE   = 10'd600;
    localparam logic [9:0] RIGHT_BASE  = 10'd230;

    // Number of quotient bits of the error divider.
    localparam int unsigned DIV_STEPS = 16;

endpackage

`default_nettype wire

// ===== rtl/line_follow_steering_controller_top.sv =====
// Line-follow steering controller: error divider, PD law, roundabout detector.
//
//  Channel   Ports                      Payload (lowest bit first)
//  -------   -------------------------  ----------------------------------------
//  input     s_tvalid/s_tready/s_tdata  left_h[11:0] right_h[23:12]
//                                       left_v[35:24] right_v[47:36]
//  result    m_tvalid/m_tready/m_tdata  steering_duty[9:0] drive_mode[11:10]
//                                       detector_armed[12] track_error[28:13]
//  config    cfg_wr_en/cfg_addr/cfg_wdata  write only, index per register list
//
// Each transaction runs through the restoring divider (one quotient bit per cycle
// through one subtractor), then one step each for error, detector, two multiply
// steps and the clamp; the clamp step waits while the output register holds a result not yet taken.
// A new transaction is not accepted until the current result has been loaded.
// s_tready is high only while the sequencer is idle; a finished result sits in
// the output register, and the next transaction may be accepted while it waits.
// Reset is synchronous and active low; it restores the register defaults and
// clears the controller state.
`default_nettype none

module line_follow_steering_controller_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // left_horizontal, right_horizontal, left_vertical, right_vertical
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // steering_duty, drive_mode, detector_armed, track_error, zero fill
    output logic [31:0]      m_tdata,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [14:0] cfg_wdata
);
    import lfsc_pkg::*;

    // Configuration registers.
    logic [9:0]  center_duty_reg, upper_limit_reg, lower_limit_reg, kp_reg, kd_reg;
    logic [14:0] error_window_reg;
    logic [7:0]  ready_hold_reg, loop_hold_reg;

    // Sequencer and datapath registers.
    state_t             state_reg, state_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [12:0]        sum_reg, sum_next;
    logic [13:0]        rem_reg, rem_next;
    logic [15:0]        quot_reg, quot_next;
    logic               neg_reg, neg_next;
    logic               zero_reg, zero_next;
    logic [11:0]        lv_reg, lv_next, rv_reg, rv_next;
    logic signed [15:0] err_reg, err_next;
    logic signed [15:0] prev_err_reg, prev_err_next;
    logic signed [16:0] diff_reg, diff_next;
    logic               round_reg, round_next;
    drive_mode_t        mode_reg, mode_next;
    logic [7:0]         hold_reg, hold_next;
    logic               armed_reg, armed_next;
    logic signed [31:0] acc_reg, acc_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [31:0]        m_tdata_reg, m_tdata_next;

    // Input unpacking and horizontal difference.
    logic [11:0] in_lh, in_rh;
    logic        in_neg;
    assign in_lh  = s_tdata[11:0];
    assign in_rh  = s_tdata[23:12];
    assign in_neg = in_lh < in_rh;

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    // Shared divider subtractor.
    logic        div_ge;
    logic [13:0] div_diff;
    assign div_diff = rem_reg - {1'b0, sum_reg};
    assign div_ge   = rem_reg >= {1'b0, sum_reg};

    // Shared multiplier: unsigned 10-bit coefficient times signed 17-bit operand.
    logic [9:0]         mul_coef;
    logic signed [16:0] mul_opnd;
    logic signed [27:0] mul_prod;
    always_comb begin
        mul_coef = kp_reg;
        mul_opnd = {err_reg[15], err_reg};
        if (state_reg == ST_MUL_P) begin
            mul_coef = round_reg ? ROUND_GAIN : kp_reg;
        end else if (state_reg == ST_MUL_D) begin
            mul_coef = round_reg ? 10'd0 : kd_reg;
            mul_opnd = diff_reg;
        end
    end
    assign mul_prod = $signed({1'b0, mul_coef}) * mul_opnd;

    // Duty from the accumulator, truncated toward zero, then clamped.
    logic signed [31:0] acc_adj;
    logic signed [16:0] duty_raw, duty_up, duty_clamped;
    logic signed [16:0] upper_s, lower_s;
    assign acc_adj      = acc_reg + (acc_reg[31] ? 32'sd32767 : 32'sd0);
    assign duty_raw     = acc_adj[31:15];
    assign upper_s      = $signed({7'd0, upper_limit_reg});
    assign lower_s      = $signed({7'd0, lower_limit_reg});
    assign duty_up      = (duty_raw >= upper_s) ? upper_s : duty_raw;
    assign duty_clamped = (duty_up <= lower_s) ? lower_s : duty_up;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_DIVIDE;
            ST_DIVIDE: if (cnt_reg == 4'(DIV_STEPS - 1)) state_next = ST_ERROR;
            ST_ERROR:  state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_MUL_P;
            ST_MUL_P:  state_next = ST_MUL_D;
            ST_MUL_D:  state_next = ST_FINISH;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and state updates per sequencer step.
    always_comb begin
        logic signed [16:0] e17, w17;
        logic               in_window, vert_ok, enter_left, enter_right;
        drive_mode_t        m;
        logic               a;
        logic [7:0]         h;

        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        neg_next      = neg_reg;
        zero_next     = zero_reg;
        lv_next       = lv_reg;
        rv_next       = rv_reg;
        err_next      = err_reg;
        prev_err_next = prev_err_reg;
        diff_next     = diff_reg;
        round_next    = round_reg;
        mode_next     = mode_reg;
        hold_next     = hold_reg;
        armed_next    = armed_reg;
        acc_next      = acc_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg;

        e17         = {err_reg[15], err_reg};
        w17         = $signed({2'b00, error_window_reg});
        in_window   = (e17 < w17) && (e17 > -w17);
        vert_ok     = (lv_reg > VERT_ARM_LOW) && (lv_reg < VERT_ARM_HIGH)
                   && (rv_reg > VERT_ARM_LOW) && (rv_reg < VERT_ARM_HIGH);
        enter_left  = 1'b0;
        enter_right = 1'b0;
        m = mode_reg;
        a = armed_reg;
        h = hold_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    sum_next  = {1'b0, in_lh} + {1'b0, in_rh};
                    rem_next  = {2'b00, (in_neg ? (in_rh - in_lh) : (in_lh - in_rh))};
                    neg_next  = in_neg;
                    zero_next = (in_lh == 12'd0) && (in_rh == 12'd0);
                    lv_next   = s_tdata[35:24];
                    rv_next   = s_tdata[47:36];
                    quot_next = '0;
                    cnt_next  = '0;
                end
            end
            ST_DIVIDE: begin
                quot_next = {quot_reg[14:0], div_ge};
                rem_next  = div_ge ? {div_diff[12:0], 1'b0} : {rem_reg[12:0], 1'b0};
                cnt_next  = cnt_reg + 4'd1;
            end
            ST_ERROR: begin
                if (zero_reg) begin
                    err_next = '0;
                end else if (neg_reg) begin
                    err_next = $signed(-quot_reg);
                end else if (quot_reg[15]) begin
                    err_next = 16'sd32767;
                end else begin
                    err_next = $signed(quot_reg);
                end
            end
            ST_DECIDE: begin
                diff_next = e17 - {prev_err_reg[15], prev_err_reg};
                if (mode_reg != MODE_LEFT && mode_reg != MODE_RIGHT) begin
                    prev_err_next = err_reg;
                    m = MODE_TRACK;
                    if (in_window) begin
                        if (vert_ok) begin
                            a = 1'b1;
                            h = ready_hold_reg;
                        end
                        // Left entry: right coil strong and well above the left one.
                        enter_left  = a && (rv_reg > VERT_ENTER)
                                   && (({1'b0, lv_reg} + VERT_IMBAL) < {1'b0, rv_reg});
                        enter_right = a && (lv_reg > VERT_ENTER)
                                   && ({1'b0, lv_reg} > ({1'b0, rv_reg} + VERT_IMBAL));
                        if (enter_left) begin
                            a = 1'b0;
                            h = loop_hold_reg;
                            m = MODE_LEFT;
                        end else if (enter_right) begin
                            a = 1'b0;
                            h = loop_hold_reg;
                            m = MODE_RIGHT;
                        end
                    end
                end
                round_next = (m == MODE_LEFT) || (m == MODE_RIGHT);
                acc_next   = (m == MODE_LEFT) ? 32'sd1 : 32'sd0;
                if (m == MODE_LEFT || m == MODE_RIGHT) begin
                    if (h != 8'd0) begin
                        h = h - 8'd1;
                    end else begin
                        m = MODE_TRACK;
                    end
                end
                if (a) begin
                    if (h != 8'd0) begin
                        h = h - 8'd1;
                    end else begin
                        a = 1'b0;
                    end
                end
                mode_next  = m;
                armed_next = a;
                hold_next  = h;
            end
            ST_MUL_P: begin
                // The decide step left a left-roundabout marker in the accumulator.
                if (round_reg) begin
                    acc_next = $signed({7'd0, (acc_reg[0] ? LEFT_BASE : RIGHT_BASE), 15'd0})
                             + 32'(mul_prod);
                end else begin
                    acc_next = $signed({7'd0, center_duty_reg, 15'd0}) + 32'(mul_prod);
                end
            end
            ST_MUL_D: begin
                acc_next = acc_reg + 32'(mul_prod);
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'd0, err_reg, armed_reg, mode_reg,
                                     duty_clamped[9:0]};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            prev_err_reg     <= '0;
            mode_reg         <= MODE_TRACK;
            hold_reg         <= '0;
            armed_reg        <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            center_duty_reg  <= RST_CENTER_DUTY;
            upper_limit_reg  <= RST_UPPER_LIMIT;
            lower_limit_reg  <= RST_LOWER_LIMIT;
            kp_reg           <= RST_KP;
            kd_reg           <= RST_KD;
            error_window_reg <= RST_ERROR_WIN;
            ready_hold_reg   <= RST_READY_HOLD;
            loop_hold_reg    <= RST_LOOP_HOLD;
        end else begin
            state_reg    <= state_next;
            prev_err_reg <= prev_err_next;
            mode_reg     <= mode_next;
            hold_reg     <= hold_next;
            armed_reg    <= armed_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_CENTER_DUTY: center_duty_reg  <= cfg_wdata[9:0];
                    CFG_UPPER_LIMIT: upper_limit_reg  <= cfg_wdata[9:0];
                    CFG_LOWER_LIMIT: lower_limit_reg  <= cfg_wdata[9:0];
                    CFG_KP:          kp_reg           <= cfg_wdata[9:0];
                    CFG_KD:          kd_reg           <= cfg_wdata[9:0];
                    CFG_ERROR_WIN:   error_window_reg <= cfg_wdata;
                    CFG_READY_HOLD:  ready_hold_reg   <= cfg_wdata[7:0];
                    CFG_LOOP_HOLD:   loop_hold_reg    <= cfg_wdata[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg     <= cnt_next;
        sum_reg     <= sum_next;
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        neg_reg     <= neg_next;
        zero_reg    <= zero_next;
        lv_reg      <= lv_next;
        rv_reg      <= rv_next;
        err_reg     <= err_next;
        diff_reg    <= diff_next;
        round_reg   <= round_next;
        acc_reg     <= acc_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The sequencer is busy right after it takes a transaction.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted again while an item is in progress");

    // A roundabout mode always runs with the detector disarmed.
    a_round_disarmed: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg != MODE_TRACK) |-> !armed_reg)
        else $error("detector armed during a roundabout");

    // The unused mode code never reaches the result.
    a_mode_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[11:10] != 2'd3))
        else $error("drive mode code out of range");

    // With ordered limits the loaded duty lies between them.
    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && out_free && upper_limit_reg >= lower_limit_reg)
        |=> (m_tdata[9:0] >= $past(lower_limit_reg))
            && (m_tdata[9:0] <= $past(upper_limit_reg)))
        else $error("steering duty outside the limits");

endmodule

`default_nettype wire

// ===== tb/lfsc_steering_checker.sv =====
// Checker for the steering controller: predicts each result and compares it with the block.
module lfsc_steering_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // left_horizontal, right_horizontal, left_vertical, right_vertical
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // steering_duty, drive_mode, detector_armed, track_error, zero fill
    input  logic [31:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [14:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lfsc_pkg::*;

    localparam int Q15_ONE      = 32768;
    localparam int ARM_LOW      = 100;
    localparam int ARM_HIGH     = 600;
    localparam int ENTER_LEVEL  = 1200;
    localparam int IMBALANCE    = 600;
    localparam int LOOP_GAIN    = 150;
    localparam int LEFT_DUTY    = 600;
    localparam int RIGHT_DUTY   = 230;

    typedef struct packed {
        logic [9:0]  duty;
        drive_mode_t mode;
        logic        armed;
        logic [15:0] err;
    } steer_result_t;

    logic [9:0]  center_duty, upper_limit, lower_limit, kp, kd;
    logic [14:0] error_window;
    logic [7:0]  ready_hold, loop_hold;

    int          prev_error;
    drive_mode_t cur_mode;
    int          hold_count;
    logic        armed;

    steer_result_t awaited_steering[$];
    int            fails = 0;

    function automatic steer_result_t predict_steering(input logic [47:0] coils);
        int lh, rh, lv, rv, sum, mag, quot, err, duty, win;
        longint acc;
        steer_result_t res;
        lh = coils[11:0];
        rh = coils[23:12];
        lv = coils[35:24];
        rv = coils[47:36];
        sum = lh + rh;
        if (sum == 0) begin
            err = 0;
        end else begin
            mag  = (lh < rh) ? rh - lh : lh - rh;
            quot = (mag * Q15_ONE) / sum;
            if (lh < rh) begin
                err = -quot;
            end else begin
                err = (quot > 32767) ? 32767 : quot;
            end
        end

        duty = 0;
        if (cur_mode != MODE_LEFT && cur_mode != MODE_RIGHT) begin
            win = int'(error_window);
            // Signed 64-bit division truncates toward zero.
            acc = longint'(center_duty) * Q15_ONE + longint'(kp) * err
                + longint'(kd) * (err - prev_error);
            duty = int'(acc / Q15_ONE);
            prev_error = err;
            cur_mode = MODE_TRACK;
            if (err < win && err > -win) begin
                if (lv > ARM_LOW && lv < ARM_HIGH && rv > ARM_LOW && rv < ARM_HIGH) begin
                    armed = 1'b1;
                    hold_count = ready_hold;
                end
                if (armed && rv > ENTER_LEVEL && (lv - rv) < -IMBALANCE) begin
                    armed = 1'b0;
                    hold_count = loop_hold;
                    cur_mode = MODE_LEFT;
                end else if (armed && lv > ENTER_LEVEL && (lv - rv) > IMBALANCE) begin
                    armed = 1'b0;
                    hold_count = loop_hold;
                    cur_mode = MODE_RIGHT;
                end
            end
        end

        if (cur_mode == MODE_LEFT || cur_mode == MODE_RIGHT) begin
            acc = longint'((cur_mode == MODE_LEFT) ? LEFT_DUTY : RIGHT_DUTY) * Q15_ONE
                + longint'(LOOP_GAIN) * err;
            duty = int'(acc / Q15_ONE);
            if (hold_count > 0) begin
                hold_count--;
            end else begin
                cur_mode = MODE_TRACK;
            end
        end

        if (armed) begin
            if (hold_count > 0) begin
                hold_count--;
            end else begin
                armed = 1'b0;
            end
        end

        // With crossed limits the lower limit is applied last and wins.
        if (duty >= int'(upper_limit)) duty = int'(upper_limit);
        if (duty <= int'(lower_limit)) duty = int'(lower_limit);

        res.duty  = 10'(duty);
        res.mode  = cur_mode;
        res.armed = armed;
        res.err   = 16'(err);
        return res;
    endfunction

    task automatic check_field(input string what, input int want_v, input int got_v);
        if (want_v != got_v) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, what, want_v, got_v);
        end
    endtask

    always @(posedge aclk) begin
        steer_result_t want;
        if (!aresetn) begin
            center_duty  = RST_CENTER_DUTY;
            upper_limit  = RST_UPPER_LIMIT;
            lower_limit  = RST_LOWER_LIMIT;
            kp           = RST_KP;
            kd           = RST_KD;
            error_window = RST_ERROR_WIN;
            ready_hold   = RST_READY_HOLD;
            loop_hold    = RST_LOOP_HOLD;
            prev_error   = 0;
            cur_mode     = MODE_TRACK;
            hold_count   = 0;
            armed        = 1'b0;
            awaited_steering.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_CENTER_DUTY: center_duty  = cfg_wdata[9:0];
                    CFG_UPPER_LIMIT: upper_limit  = cfg_wdata[9:0];
                    CFG_LOWER_LIMIT: lower_limit  = cfg_wdata[9:0];
                    CFG_KP:          kp           = cfg_wdata[9:0];
                    CFG_KD:          kd           = cfg_wdata[9:0];
                    CFG_ERROR_WIN:   error_window = cfg_wdata;
                    CFG_READY_HOLD:  ready_hold   = cfg_wdata[7:0];
                    CFG_LOOP_HOLD:   loop_hold    = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                awaited_steering.push_back(predict_steering(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                if (awaited_steering.size() == 0) begin
                    fails++;
                    $display("%0t: result with no transaction waiting, expected none, actual %h",
                             $time, m_tdata);
                end else begin
                    want = awaited_steering.pop_front();
                    check_field("steering_duty", want.duty, m_tdata[9:0]);
                    check_field("drive_mode", int'(want.mode), m_tdata[11:10]);
                    check_field("detector_armed", want.armed, m_tdata[12]);
                    check_field("track_error", int'($signed(want.err)),
                                int'($signed(m_tdata[28:13])));
                end
            end
        end
        pending    <= awaited_steering.size();
        fail_count <= fails;
    end

endmodule

// ===== tb/line_follow_steering_controller_top_tb.sv =====
// Testbench top for the steering controller: clock, reset, stimulus and verdict.
module line_follow_steering_controller_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lfsc_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [14:0] cfg_wdata;

    int   fail_count;
    int   pending;
    logic no_idle;
    logic long_stall;
    int   loop_ticks;

    line_follow_steering_controller_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    lfsc_steering_checker steer_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("FAIL line_follow_steering_controller_top");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off that lets the block fill up.
    initial begin : result_sink
        int stall_left;
        bit stall_used;
        stall_left = 0;
        stall_used = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_stall && !stall_used) begin
                stall_used = 1'b1;
                stall_left = 400;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= no_idle || ($urandom_range(99) >= 34);
            end
        end
    end

    function automatic logic [47:0] pack_coils(input int lh, input int rh,
                                               input int lv, input int rv);
        return {12'(rv), 12'(lv), 12'(rh), 12'(lh)};
    endfunction

    function automatic int any_count();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return 0;
        if (pick == 1) return 4095;
        return $urandom_range(4095);
    endfunction

    function automatic logic [47:0] random_coils();
        return pack_coils(any_count(), any_count(), any_count(), any_count());
    endfunction

    // Horizontal pair close to balance, so the detector sees a small error.
    function automatic logic [47:0] centered_coils(input int lv, input int rv);
        int lh, rh;
        lh = $urandom_range(200, 4000);
        if ($urandom_range(3) == 0) begin
            rh = lh;
        end else begin
            rh = lh - lh / 8 + $urandom_range(lh / 4);
            if (rh > 4095) rh = 4095;
        end
        return pack_coils(lh, rh, lv, rv);
    endfunction

    function automatic logic [47:0] entry_coils(input bit to_right);
        int strong_side, weak_side;
        strong_side = ($urandom_range(7) == 0) ? 1201 : $urandom_range(1201, 4095);
        weak_side   = ($urandom_range(7) == 0) ? strong_side - 601
                                               : $urandom_range(strong_side - 601);
        return to_right ? centered_coils(strong_side, weak_side)
                        : centered_coils(weak_side, strong_side);
    endfunction

    task automatic push_reading(input logic [47:0] coils);
        while (!no_idle && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= coils;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Waits until every result is back, then lets the sequencer settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (30) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [2:0] idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= 15'(value);
        @(posedge aclk);
    endtask

    task automatic write_settings(input int center, input int upper, input int lower,
                                  input int p_gain, input int d_gain, input int window,
                                  input int ready_ticks, input int round_ticks);
        set_reg(CFG_CENTER_DUTY, center);
        set_reg(CFG_UPPER_LIMIT, upper);
        set_reg(CFG_LOWER_LIMIT, lower);
        set_reg(CFG_KP, p_gain);
        set_reg(CFG_KD, d_gain);
        set_reg(CFG_ERROR_WIN, window);
        set_reg(CFG_READY_HOLD, ready_ticks);
        set_reg(CFG_LOOP_HOLD, round_ticks);
        cfg_wr_en <= 1'b0;
        loop_ticks = round_ticks;
    endtask

    // Mostly full roundabout approaches (arm, entry, ride through the hold), some noise.
    task automatic run_random(input int count);
        int sent, n;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 65) begin
                push_reading(centered_coils($urandom_range(101, 599), $urandom_range(101, 599)));
                sent++;
                n = $urandom_range(2);
                while (n > 0 && sent < count) begin
                    push_reading(centered_coils(any_count(), any_count()));
                    sent++;
                    n--;
                end
                if (sent < count) begin
                    push_reading(entry_coils($urandom_range(1)));
                    sent++;
                end
                n = loop_ticks + $urandom_range(3);
                while (n > 0 && sent < count) begin
                    push_reading($urandom_range(1) ? random_coils()
                                                   : centered_coils(any_count(), any_count()));
                    sent++;
                    n--;
                end
            end else begin
                n = $urandom_range(1, 8);
                while (n > 0 && sent < count) begin
                    push_reading(random_coils());
                    sent++;
                    n--;
                end
            end
        end
    endtask

    initial begin
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        cfg_wr_en  <= 1'b0;
        cfg_addr   <= '0;
        cfg_wdata  <= '0;
        no_idle    <= 1'b0;
        long_stall <= 1'b0;
        aresetn    <= 1'b0;
        loop_ticks = 40;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Short hold counts so that arming, entry and expiry all fit in a few transactions.
        write_settings(390, 600, 180, 320, 250, 6554, 2, 3);
        push_reading(pack_coils(0, 0, 0, 0));
        push_reading(pack_coils(4095, 0, 4095, 0));
        push_reading(pack_coils(0, 4095, 4095, 4095));
        push_reading(pack_coils(4095, 1, 0, 4095));
        push_reading(pack_coils(2000, 2000, 100, 600));
        push_reading(pack_coils(2000, 2000, 101, 599));
        push_reading(pack_coils(2000, 2000, 600, 1200));
        push_reading(pack_coils(2000, 2000, 600, 1201));
        push_reading(pack_coils(3000, 1000, 2000, 2000));
        push_reading(pack_coils(0, 4095, 0, 0));
        push_reading(pack_coils(4095, 0, 0, 0));
        push_reading(pack_coils(1000, 3000, 0, 0));
        push_reading(pack_coils(2000, 2010, 300, 300));
        push_reading(pack_coils(2000, 2000, 1801, 1200));
        push_reading(pack_coils(1500, 2500, 4095, 0));
        push_reading(pack_coils(4095, 4095, 4095, 4095));
        push_reading(pack_coils(2500, 1500, 0, 4095));
        push_reading(pack_coils(1, 4095, 300, 300));
        push_reading(pack_coils(2000, 2000, 200, 200));
        push_reading(pack_coils(2000, 2000, 0, 0));
        push_reading(pack_coils(2000, 2000, 0, 0));
        push_reading(pack_coils(2000, 2000, 150, 150));
        push_reading(pack_coils(2000, 2000, 1201, 601));
        push_reading(pack_coils(2000, 2000, 1201, 600));
        drain_results();

        long_stall <= 1'b1;
        write_settings(390, 600, 180, 320, 250, 6554, 20, 40);
        run_random(150);
        drain_results();

        write_settings(1023, 1023, 1023, 1023, 1023, 32767, 255, 255);
        run_random(100);
        drain_results();

        write_settings(0, 0, 0, 0, 0, 0, 0, 0);
        run_random(100);
        drain_results();

        // Upper limit below lower limit.
        write_settings(512, 100, 900, 1023, 0, 16384, 0, 0);
        run_random(120);
        drain_results();

        no_idle <= 1'b1;
        write_settings(200, 1000, 0, 1023, 1023, 32767, 5, 10);
        run_random(150);
        drain_results();
        no_idle <= 1'b0;

        repeat (2) begin
            write_settings($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                           $urandom_range(1023), $urandom_range(1023), $urandom_range(32767),
                           $urandom_range(255), $urandom_range(255));
            run_random(140);
            drain_results();
        end

        if (fail_count == 0) begin
            $display("PASS line_follow_steering_controller_top");
        end else begin
            $display("FAIL line_follow_steering_controller_top");
        end
        $finish;
    end

endmodule
